### rtl/core/positional_sequence_range_max_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the positional sequence range max block
// Shared property wrappers; every check is clocked and off during reset.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_SEQUENCE_RANGE_MAX_DEFINES_SVH
`define POSITIONAL_SEQUENCE_RANGE_MAX_DEFINES_SVH

// Same-cycle implication
`define PSRM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PSRM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/psrm_pkg.sv
// ----------------------------------------------------------------------------
// psrm_pkg
// Types, codes and field widths shared by the sequence range max block.
// ----------------------------------------------------------------------------
package psrm_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;

  // Field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned POS_W     = 11;
  localparam int unsigned RPOS_W    = 10;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned CNT_OUT_W = 11;

  // Stream widths, padded to whole bytes
  localparam int unsigned S_TDATA_W = 56;
  localparam int unsigned M_TDATA_W = 48;
  localparam int unsigned S_PAD_W   = S_TDATA_W - POS_W - RPOS_W - VAL_W;
  localparam int unsigned M_PAD_W   = M_TDATA_W - VAL_W - CNT_OUT_W;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_MAX    = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // Memory port strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  // One result item
  typedef struct packed {
    status_e               status;
    logic signed [VAL_W-1:0] max_value;
    logic [CNT_OUT_W-1:0]  entry_count;
  } result_t;

endpackage

### rtl/core/psrm_ram.sv
// ----------------------------------------------------------------------------
// psrm_ram
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module psrm_ram
  import psrm_pkg::*;
#(
  parameter  int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned AW       = $clog2(CAPACITY)
) (
  input  logic             clk_i,
  input  mem_ctl_t         ctl_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [VAL_W-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [VAL_W-1:0] rdata_o
);

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata_q;

  // Write, and read into the registered read data
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/psrm_seq.sv
// ----------------------------------------------------------------------------
// psrm_seq
// Operation sequencer: checks the request, then walks the store one entry a
// cycle to shift the tail or scan the range.
// ----------------------------------------------------------------------------
module psrm_seq
  import psrm_pkg::*;
#(
  parameter  int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned AW       = $clog2(CAPACITY),
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [POS_W-1:0]  pos_i,
  input  logic [RPOS_W-1:0] rpos_i,
  input  logic [VAL_W-1:0]  val_i,
  input  logic              out_free_i,
  output logic              res_valid_o,
  output result_t           res_o,
  output mem_ctl_t          mem_ctl_o,
  output logic [AW-1:0]     waddr_o,
  output logic [VAL_W-1:0]  wdata_o,
  output logic [AW-1:0]     raddr_o,
  input  logic [VAL_W-1:0]  rdata_i
);

  // Compare width covering both the position field and the count
  localparam int unsigned CW = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_WRV  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        left_q, left_d;
  logic                    pend_q, pend_d;
  op_e                     op_q, op_d;
  status_e                 st_q, st_d;
  logic [AW-1:0]           ptr_q, ptr_d;
  logic [AW-1:0]           paddr_q, paddr_d;
  logic [AW-1:0]           pos_q, pos_d;
  logic [VAL_W-1:0]        val_q, val_d;
  logic signed [VAL_W-1:0] best_q, best_d;
  logic                    have_q, have_d;

  logic [CW-1:0] pos_w, rpos_w, cnt_w, cap_w;
  status_e       chk_st;
  logic [CW-1:0] chk_left;
  logic [CW-1:0] chk_start;

  assign pos_w  = CW'(pos_i);
  assign rpos_w = CW'(rpos_i);
  assign cnt_w  = CW'(count_q);
  assign cap_w  = CW'(CAPACITY);

  // Request check, move count and first read address
  always_comb begin
    chk_st    = ST_OK;
    chk_left  = '0;
    chk_start = '0;
    case (op_e'(op_i))
      OP_INSERT: begin
        if (pos_w > cnt_w) begin
          chk_st = ST_BAD_POS;
        end else if (cnt_w >= cap_w) begin
          chk_st = ST_FULL;
        end
        chk_left  = cnt_w - pos_w;
        chk_start = cnt_w - CW'(1);
      end
      OP_ERASE: begin
        if (pos_w >= cnt_w) begin
          chk_st = ST_BAD_POS;
        end
        chk_left  = cnt_w - pos_w - CW'(1);
        chk_start = pos_w + CW'(1);
      end
      OP_MAX: begin
        if (pos_w > rpos_w) begin
          chk_st = ST_EMPTY;
        end else if (rpos_w >= cnt_w) begin
          chk_st = ST_BAD_POS;
        end
        chk_left  = rpos_w - pos_w + CW'(1);
        chk_start = pos_w;
      end
      default: begin
        chk_st = ST_OK;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    left_d      = left_q;
    pend_d      = 1'b0;
    op_d        = op_q;
    st_d        = st_q;
    ptr_d       = ptr_q;
    paddr_d     = paddr_q;
    pos_d       = pos_q;
    val_d       = val_q;
    best_d      = best_q;
    have_d      = have_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_ctl_o   = '0;
    raddr_o     = ptr_q;
    waddr_o     = paddr_q;
    wdata_o     = rdata_i;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d   = op_e'(op_i);
          st_d   = chk_st;
          pos_d  = AW'(pos_i);
          val_d  = val_i;
          left_d = CNT_W'(chk_left);
          ptr_d  = AW'(chk_start);
          have_d = 1'b0;
          if ((chk_st == ST_OK) && (op_e'(op_i) != OP_NONE)) begin
            state_d = S_RUN;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      S_RUN: begin
        // Issue the next read
        if (left_q != '0) begin
          mem_ctl_o.rd_en = 1'b1;
          left_d  = left_q - CNT_W'(1);
          ptr_d   = (op_q == OP_INSERT) ? ptr_q - AW'(1) : ptr_q + AW'(1);
          pend_d  = 1'b1;
          paddr_d = ptr_q;
        end
        // Consume the data read last cycle
        if (pend_q) begin
          case (op_q)
            OP_INSERT: begin
              mem_ctl_o.wr_en = 1'b1;
              waddr_o = paddr_q + AW'(1);
            end
            OP_ERASE: begin
              mem_ctl_o.wr_en = 1'b1;
              waddr_o = paddr_q - AW'(1);
            end
            default: begin
              if (!have_q || ($signed(rdata_i) > best_q)) begin
                best_d = $signed(rdata_i);
              end
              have_d = 1'b1;
            end
          endcase
        end
        if ((left_q == '0) && !pend_q) begin
          case (op_q)
            OP_INSERT: state_d = S_WRV;
            OP_ERASE: begin
              count_d = count_q - CNT_W'(1);
              state_d = S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_WRV: begin
        // Place the new value into the opened slot
        mem_ctl_o.wr_en = 1'b1;
        waddr_o = pos_q;
        wdata_o = val_q;
        count_d = count_q + CNT_W'(1);
        state_d = S_DONE;
      end

      S_DONE: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result item
  always_comb begin
    res_o.status      = st_q;
    res_o.max_value   = ((st_q == ST_OK) && (op_q == OP_MAX)) ? best_q : '0;
    res_o.entry_count = CNT_OUT_W'(count_q);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      left_q  <= '0;
      pend_q  <= 1'b0;
      have_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      left_q  <= left_d;
      pend_q  <= pend_d;
      have_q  <= have_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    st_q    <= st_d;
    ptr_q   <= ptr_d;
    paddr_q <= paddr_d;
    pos_q   <= pos_d;
    val_q   <= val_d;
    best_q  <= best_d;
  end

endmodule

### rtl/core/positional_sequence_range_max.sv
// ----------------------------------------------------------------------------
// positional_sequence_range_max
// Ordered sequence of signed values with insert, erase and range maximum.
// ----------------------------------------------------------------------------
// One item is in work at a time. Insert and erase move each entry that lies
// behind the position, and a range maximum over l..r scans each entry from l
// to r; a rejected request or the unused operation touches no entry. A full
// output register holds the result back until it can get out. The pace is set
// by the element memory, whose single read port moves or scans one entry a
// cycle. The store needs no clearing after reset: only entries below the
// count are ever read. A finished result sits in an output register, so the
// next item is taken while it waits.
module positional_sequence_range_max
  import psrm_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // position[10:0], right_position[20:11], value[52:21], zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // operation[1:0]
  input  logic [OP_W-1:0]      s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // max_value[31:0], entry_count[42:32], zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // status[1:0]
  output logic [ST_W-1:0]      m_axis_tuser
);

  localparam int unsigned AW = $clog2(CAPACITY);

  mem_ctl_t         mem_ctl;
  logic [AW-1:0]    waddr, raddr;
  logic [VAL_W-1:0] wdata, rdata;
  logic             res_valid;
  result_t          res;
  logic             m_valid_q;
  result_t          m_res_q;
  logic             out_free;

  assign out_free = !m_valid_q || m_axis_tready;

  psrm_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tuser),
    .pos_i      (s_axis_tdata[POS_W-1:0]),
    .rpos_i     (s_axis_tdata[POS_W+RPOS_W-1:POS_W]),
    .val_i      (s_axis_tdata[POS_W+RPOS_W+VAL_W-1:POS_W+RPOS_W]),
    .out_free_i (out_free),
    .res_valid_o(res_valid),
    .res_o      (res),
    .mem_ctl_o  (mem_ctl),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .raddr_o    (raddr),
    .rdata_i    (rdata)
  );

  psrm_ram #(
    .CAPACITY(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .ctl_i  (mem_ctl),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_res_q.status;
  assign m_axis_tdata  = {{M_PAD_W{1'b0}}, m_res_q.entry_count, m_res_q.max_value};

endmodule

### rtl/core/psrm_checker.sv
// ----------------------------------------------------------------------------
// psrm_checker
// Port-level checks for the sequence range max block, bound to the top.
// ----------------------------------------------------------------------------
`include "positional_sequence_range_max_defines.svh"

module psrm_checker
  import psrm_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  // position[10:0], right_position[20:11], value[52:21], zero pad
  input logic [S_TDATA_W-1:0] s_axis_tdata,
  // operation[1:0]
  input logic [OP_W-1:0]      s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  // max_value[31:0], entry_count[42:32], zero pad
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  // status[1:0]
  input logic [ST_W-1:0]      m_axis_tuser
);

  // A stalled result holds
  `PSRM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // One item in work at a time: intake closes after a transfer
  `PSRM_ASSERT_NXT(a_one_item, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "intake open right after a transfer")

  // A failed request reports a zero maximum
  `PSRM_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata[VAL_W-1:0] == '0, "nonzero maximum on failed request")

  // Count never exceeds the capacity
  `PSRM_ASSERT_IMP(a_cnt_cap, clk_i, rst_ni, m_axis_tvalid, (CAPACITY > 2047) || (m_axis_tdata[VAL_W+CNT_OUT_W-1:VAL_W] <= CAPACITY), "entry count above capacity")

endmodule

bind positional_sequence_range_max psrm_checker #(.CAPACITY(CAPACITY)) u_psrm_checker (.*);

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level testbench for the positional sequence range max block.
// Operations go in through a backlog queue and a bursty driver. Each
// accepted operation is run on a queue-based model of the sequence, and the
// predicted reply is compared field by field with what the block returns.
// The reply side stalls on a changing pattern, including one long hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import psrm_pkg::*;

  localparam int unsigned CAP         = CAPACITY_DEF;
  localparam int          N_RANDOM    = 546;
  localparam int          IDLE_LIMIT  = 20000;
  localparam int          HOLDOFF_LEN = 2000;
  localparam int          DRAIN_CYC   = 50;

  // One requested operation
  typedef struct {
    op_e              op;
    logic [POS_W-1:0]  pos;
    logic [RPOS_W-1:0] rpos;
    logic [VAL_W-1:0]  value;
  } seq_req_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // position[10:0], right_position[20:11], value[52:21], zero pad
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  // operation[1:0]
  logic [OP_W-1:0]      s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // max_value[31:0], entry_count[42:32], zero pad
  logic [M_TDATA_W-1:0] m_axis_tdata;
  // status[1:0]
  logic [ST_W-1:0]      m_axis_tuser;

  // Stimulus backlog, model of the stored sequence, predicted replies
  seq_req_t                op_backlog[$];
  logic signed [VAL_W-1:0] seq_model[$];
  result_t                 predicted_replies[$];

  int gen_count  = 0;
  int n_total    = 0;
  int n_accepted = 0;
  int n_errors   = 0;

  positional_sequence_range_max #(
    .CAPACITY(CAP)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock and reset
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Apply one operation to the sequence model and return the reply
  function automatic result_t seq_apply(input seq_req_t req);
    result_t                 res;
    logic signed [VAL_W-1:0] best;
    int                      lo;
    int                      hi;
    int                      n;
    res.status    = ST_OK;
    res.max_value = '0;
    n  = seq_model.size();
    lo = int'(req.pos);
    hi = int'(req.rpos);
    case (req.op)
      OP_INSERT: begin
        if (lo > n) res.status = ST_BAD_POS;
        else if (n >= int'(CAP)) res.status = ST_FULL;
        else seq_model.insert(lo, $signed(req.value));
      end
      OP_ERASE: begin
        if (lo >= n) res.status = ST_BAD_POS;
        else seq_model.delete(lo);
      end
      OP_MAX: begin
        if (lo > hi) begin
          res.status = ST_EMPTY;
        end else if (hi >= n) begin
          res.status = ST_BAD_POS;
        end else begin
          best = seq_model[lo];
          for (int i = lo + 1; i <= hi; i++)
            if (seq_model[i] > best) best = seq_model[i];
          res.max_value = best;
        end
      end
      default: ;
    endcase
    res.entry_count = CNT_OUT_W'(seq_model.size());
    return res;
  endfunction

  // Queue one operation; the running count keeps random positions in range
  task automatic queue_op(input op_e op, input int pos, input int rpos,
                          input logic [VAL_W-1:0] value);
    seq_req_t req;
    req.op    = op;
    req.pos   = pos[POS_W-1:0];
    req.rpos  = rpos[RPOS_W-1:0];
    req.value = value;
    op_backlog.push_back(req);
    n_total++;
    if (op == OP_INSERT && pos <= gen_count && gen_count < int'(CAP)) gen_count++;
    else if (op == OP_ERASE && pos < gen_count) gen_count--;
  endtask

  // Random value with the extremes mixed in
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Build the stimulus, then wait for every reply
  initial begin
    int r;
    int lo;
    int hi;

    // Empty store: every position is past the end
    queue_op(OP_MAX,    0,    0,    32'h0);
    queue_op(OP_ERASE,  0,    0,    32'h0);
    queue_op(OP_INSERT, 1,    0,    32'h1234_5678);
    queue_op(OP_INSERT, 1024, 0,    32'h1234_5678);
    queue_op(OP_NONE,   5,    7,    $urandom());
    // Extreme values, append and insert in the middle
    queue_op(OP_INSERT, 0,    0,    32'h8000_0000);
    queue_op(OP_INSERT, 1,    0,    32'h7fff_ffff);
    queue_op(OP_INSERT, 1,    0,    32'hffff_ffff);
    queue_op(OP_INSERT, 0,    0,    32'h0000_0000);
    // Range maximum: whole range, reversed, past the end, one and two entries
    queue_op(OP_MAX,    0,    3,    32'h0);
    queue_op(OP_MAX,    3,    0,    32'h0);
    queue_op(OP_MAX,    0,    4,    32'h0);
    queue_op(OP_MAX,    1,    1,    32'h0);
    queue_op(OP_MAX,    1,    2,    32'h0);
    // Erase past the end, last and first entry
    queue_op(OP_ERASE,  4,    0,    32'h0);
    queue_op(OP_ERASE,  3,    0,    32'h0);
    queue_op(OP_ERASE,  0,    0,    32'h0);
    // Largest field values
    queue_op(OP_INSERT, 2047, 1023, 32'hffff_ffff);
    queue_op(OP_ERASE,  2047, 1023, 32'hffff_ffff);
    queue_op(OP_MAX,    2047, 1023, 32'hffff_ffff);
    queue_op(OP_MAX,    0,    1023, 32'h0);
    queue_op(OP_NONE,   2047, 1023, 32'hffff_ffff);

    // Random mix, mostly valid positions
    for (int k = 0; k < N_RANDOM; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        queue_op(OP_INSERT, $urandom_range(0, gen_count), $urandom_range(0, 1023),
                 pick_value());
      end else if (r < 70) begin
        lo = (gen_count > 0) ? $urandom_range(0, gen_count - 1) : 0;
        queue_op(OP_ERASE, lo, $urandom_range(0, 1023), $urandom());
      end else if (r < 92 && gen_count > 0) begin
        lo = $urandom_range(0, gen_count - 1);
        if ($urandom_range(0, 4) == 0) hi = $urandom_range(lo, gen_count - 1);
        else hi = lo + $urandom_range(0, (gen_count - 1 - lo < 63) ? gen_count - 1 - lo : 63);
        queue_op(OP_MAX, lo, hi, $urandom());
      end else if (r < 95) begin
        queue_op(OP_NONE, $urandom_range(0, 2047), $urandom_range(0, 1023), $urandom());
      end else begin
        // Malformed: any position, any range
        queue_op(op_e'($urandom_range(0, 2)), $urandom_range(0, 2047),
                 $urandom_range(0, 1023), $urandom());
      end
    end

    // Positions near the top of the range on the filled part of the store
    queue_op(OP_INSERT, 0,    0,    $urandom());
    queue_op(OP_INSERT, 1024, 0,    $urandom());
    queue_op(OP_INSERT, 500,  0,    $urandom());
    queue_op(OP_INSERT, 1025, 0,    $urandom());
    queue_op(OP_MAX,    0,    1023, 32'h0);
    queue_op(OP_MAX,    1000, 1023, 32'h0);
    queue_op(OP_ERASE,  0,    0,    32'h0);
    queue_op(OP_INSERT, 0,    0,    32'h7fff_ffff);
    queue_op(OP_MAX,    0,    1023, 32'h0);
    queue_op(OP_ERASE,  1023, 0,    32'h0);
    queue_op(OP_ERASE,  1023, 0,    32'h0);
    queue_op(OP_MAX,    512,  1022, 32'h0);

    while (n_accepted < n_total) @(posedge clk_i);
    while (predicted_replies.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (n_errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Driver: bursts of transfers with random gaps between them
  seq_req_t cur_req;
  int       burst_left = 0;
  int       gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_replies.push_back(seq_apply(cur_req));
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (op_backlog.size() > 0) begin
          cur_req = op_backlog.pop_front();
          s_axis_tuser  <= cur_req.op;
          s_axis_tdata  <= {{S_PAD_W{1'b0}}, cur_req.value, cur_req.rpos, cur_req.pos};
          s_axis_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern that changes mode, plus one long hold-off
  int rx_mode      = 0;
  int rx_left      = 0;
  int rx_seen      = 0;
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) rx_seen++;
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(64, 512);
      end else begin
        rx_left--;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        m_axis_tready <= 1'b0;
      end else if (!holdoff_done && rx_seen >= 150) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_LEN;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Monitor: compare each reply with the oldest prediction
  result_t want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (predicted_replies.size() == 0) begin
        $error("reply with no operation pending");
        n_errors++;
      end else begin
        want = predicted_replies.pop_front();
        if (m_axis_tuser != want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          n_errors++;
        end
        if (m_axis_tdata[VAL_W-1:0] != want.max_value) begin
          $error("max_value: expected %0d, got %0d", want.max_value,
                 $signed(m_axis_tdata[VAL_W-1:0]));
          n_errors++;
        end
        if (m_axis_tdata[VAL_W +: CNT_OUT_W] != want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 m_axis_tdata[VAL_W +: CNT_OUT_W]);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: cycles without any transfer on either side
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
